[hdl/bpt_pkg.sv]
`default_nettype none
package bpt_pkg;

    localparam int X_W        = 10;
    localparam int DIAM_W     = 8;
    localparam int THR_W      = 6;
    localparam int ZONE_W     = 4;
    localparam int DIR_W      = 2;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int ZONE_WIDTH  = 40;
    localparam int IMAGE_WIDTH = 320;
    localparam int NUM_ZONES   = IMAGE_WIDTH / ZONE_WIDTH;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIAM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic [DIAM_W-1:0] MIN_DIAM_RESET  = 8'd4;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 6'd15;

    localparam logic [CMD_W-1:0] CMD_STOP         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FWD_RIGHT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BACK_RIGHT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FWD_LEFT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BACK_LEFT    = 3'd4;

    localparam logic signed [DIR_W-1:0] DIR_LEFT  = -2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_NONE  = 2'sd0;
    localparam logic signed [DIR_W-1:0] DIR_RIGHT = 2'sd1;

    typedef struct packed {
        logic            seen;
        logic [X_W-1:0]  best_x;
        logic            obs_right;
        logic            obs_left;
        logic            obs_back;
    } frame_rec_t;

    // x / ZONE_WIDTH by counting boundaries passed, then shifted to -4..-1, 1..4
    function automatic logic signed [ZONE_W-1:0] zone_of(input logic [X_W-1:0] x);
        logic [ZONE_W-1:0] z;
        z = '0;
        if (x >= X_W'(IMAGE_WIDTH))
        begin
            zone_of = ZONE_W'(NUM_ZONES / 2);
        end
        else
        begin
            for (int k = 1; k < NUM_ZONES; k++)
            begin
                if (x >= X_W'(k * ZONE_WIDTH))
                    z = z + 1'b1;
            end
            if (z < ZONE_W'(NUM_ZONES / 2))
                zone_of = $signed(z - ZONE_W'(NUM_ZONES / 2));
            else
                zone_of = $signed(z - ZONE_W'(NUM_ZONES / 2 - 1));
        end
    endfunction

endpackage
`default_nettype wire

[hdl/bpt_front.sv]
`default_nettype none
module bpt_front
    import bpt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              ball_valid,
    input  wire logic [DIAM_W-1:0] ball_diameter,
    input  wire logic [X_W-1:0]    ball_x,
    input  wire logic              frame_last,
    input  wire logic              obstacle_right,
    input  wire logic              obstacle_left,
    input  wire logic              obstacle_back,
    input  wire logic [DIAM_W-1:0] min_diam,
    output logic                   push,
    output frame_rec_t             push_rec,
    input  wire logic              queue_full
);

    logic [DIAM_W-1:0] best_diam_reg, best_diam_next;
    logic [X_W-1:0]    best_x_reg, best_x_next;
    logic [DIAM_W-1:0] cand_diam;
    logic [X_W-1:0]    cand_x;
    logic              accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // strictly larger replaces, so ties keep the earlier ball
        if (ball_valid && (ball_diameter > best_diam_reg))
        begin
            cand_diam = ball_diameter;
            cand_x    = ball_x;
        end
        else
        begin
            cand_diam = best_diam_reg;
            cand_x    = best_x_reg;
        end

        best_diam_next = best_diam_reg;
        best_x_next    = best_x_reg;
        if (accept)
        begin
            if (frame_last)
            begin
                best_diam_next = '0;
                best_x_next    = '0;
            end
            else
            begin
                best_diam_next = cand_diam;
                best_x_next    = cand_x;
            end
        end

        push               = accept && frame_last;
        push_rec.seen      = (cand_diam >= min_diam);
        push_rec.best_x    = cand_x;
        push_rec.obs_right = obstacle_right;
        push_rec.obs_left  = obstacle_left;
        push_rec.obs_back  = obstacle_back;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_diam_reg <= '0;
            best_x_reg    <= '0;
        end
        else
        begin
            best_diam_reg <= best_diam_next;
            best_x_reg    <= best_x_next;
        end
    end

endmodule
`default_nettype wire

[hdl/bpt_queue.sv]
`default_nettype none
module bpt_queue
    import bpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire frame_rec_t push_rec,
    output logic            full,
    output logic            not_empty,
    input  wire logic       pop,
    output frame_rec_t      pop_rec
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_rec   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule
`default_nettype wire

[hdl/bpt_back.sv]
`default_nettype none
module bpt_back
    import bpt_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rec_valid,
    input  wire frame_rec_t               rec,
    output logic                          pop,
    input  wire logic [THR_W-1:0]         threshold,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [CMD_W-1:0]              motion_command,
    output logic signed [DIR_W-1:0]       move_direction,
    output logic signed [ZONE_W-1:0]      ball_zone
);

    localparam int SUM_W = $clog2(HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2 + 1);
    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

    logic [HISTORY_DEPTH-1:0]   hist_reg, hist_next;
    logic [X_W-1:0]             held_x_reg, held_x_next;
    logic signed [DIR_W-1:0]    held_dir_reg, held_dir_next;
    logic signed [ZONE_W-1:0]   zone_reg, zone_next;
    logic                       out_valid_reg, out_valid_next;
    logic [CMD_W-1:0]           cmd_reg, cmd_next;

    logic [SUM_W-1:0]           sum;
    logic                       tracked;
    logic [X_W-1:0]             x_use;
    logic signed [ZONE_W-1:0]   nz;
    logic signed [DIR_W-1:0]    zdir;

    assign pop            = rec_valid && (!out_valid_reg || out_ready);
    assign out_valid      = out_valid_reg;
    assign motion_command = cmd_reg;
    assign move_direction = held_dir_reg;
    assign ball_zone      = zone_reg;

    always_comb
    begin
        hist_next = {hist_reg[HISTORY_DEPTH-2:0], rec.seen};

        // newest frame weighs HISTORY_DEPTH, oldest weighs 1
        sum = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++)
        begin
            if (hist_next[k])
                sum = sum + SUM_W'(HISTORY_DEPTH - k);
        end
        tracked = (CMP_W'(sum) >= CMP_W'(threshold));

        x_use = rec.seen ? rec.best_x : held_x_reg;
        nz    = zone_of(x_use);

        // same zone: center zones give no move, outer zones keep pushing outward
        if (nz == zone_reg)
        begin
            if (nz > 4'sd1)
                zdir = DIR_RIGHT;
            else if (nz < -4'sd1)
                zdir = DIR_LEFT;
            else
                zdir = DIR_NONE;
        end
        else if (nz > zone_reg)
            zdir = DIR_RIGHT;
        else
            zdir = DIR_LEFT;

        if (tracked)
        begin
            held_x_next   = x_use;
            zone_next     = nz;
            held_dir_next = zdir;
        end
        else if (sum != '0)
        begin
            held_x_next   = '0;
            zone_next     = '0;
            held_dir_next = held_dir_reg;
        end
        else
        begin
            held_x_next   = '0;
            zone_next     = '0;
            held_dir_next = DIR_NONE;
        end

        if (held_dir_next == DIR_RIGHT)
            cmd_next = rec.obs_right ? CMD_STOP : (rec.obs_back ? CMD_FWD_RIGHT : CMD_BACK_RIGHT);
        else if (held_dir_next == DIR_LEFT)
            cmd_next = rec.obs_left ? CMD_STOP : (rec.obs_back ? CMD_FWD_LEFT : CMD_BACK_LEFT);
        else
            cmd_next = CMD_STOP;

        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            held_x_reg    <= '0;
            held_dir_reg  <= DIR_NONE;
            zone_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                hist_reg     <= hist_next;
                held_x_reg   <= held_x_next;
                held_dir_reg <= held_dir_next;
                zone_reg     <= zone_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= cmd_next;
    end

endmodule
`default_nettype wire

[hdl/ball_presence_tracker.sv]
// Ball presence tracker: one motion command per frame_last transaction.
// An accepted frame_last item is written to the queue (front accumulate and queue
// write); the back end then evaluates it and registers the result with out_valid.
// Throughput: 1 item per cycle until the queue fills; the back end retires one frame per cycle unless out_ready stalls.
// Reset (rst_n, async, active low): history, held x/direction/zone and frame
// best cleared; registers back to min diameter 4 and threshold 15.
`default_nettype none
module ball_presence_tracker
    import bpt_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  ball_valid,
    input  wire logic [DIAM_W-1:0]     ball_diameter,
    input  wire logic [X_W-1:0]        ball_x,
    input  wire logic                  frame_last,
    input  wire logic                  obstacle_right,
    input  wire logic                  obstacle_left,
    input  wire logic                  obstacle_back,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [CMD_W-1:0]           motion_command,
    output logic signed [DIR_W-1:0]    move_direction,
    output logic signed [ZONE_W-1:0]   ball_zone,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DIAM_W-1:0] min_diam_reg;
    logic [THR_W-1:0]  thr_reg;

    logic       push;
    frame_rec_t push_rec;
    logic       queue_full;
    logic       queue_not_empty;
    logic       pop;
    frame_rec_t pop_rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_diam_reg <= MIN_DIAM_RESET;
            thr_reg      <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_DIAM:  min_diam_reg <= cfg_data[DIAM_W-1:0];
                CFG_THRESHOLD: thr_reg      <= cfg_data[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    bpt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ball_valid     (ball_valid),
        .ball_diameter  (ball_diameter),
        .ball_x         (ball_x),
        .frame_last     (frame_last),
        .obstacle_right (obstacle_right),
        .obstacle_left  (obstacle_left),
        .obstacle_back  (obstacle_back),
        .min_diam       (min_diam_reg),
        .push           (push),
        .push_rec       (push_rec),
        .queue_full     (queue_full)
    );

    bpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .pop       (pop),
        .pop_rec   (pop_rec)
    );

    bpt_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rec_valid      (queue_not_empty),
        .rec            (pop_rec),
        .pop            (pop),
        .threshold      (thr_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .motion_command (motion_command),
        .move_direction (move_direction),
        .ball_zone      (ball_zone)
    );

endmodule
`default_nettype wire

[hdl/bpt_checker.sv]
`default_nettype none
module bpt_checker
    import bpt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [CMD_W-1:0]      motion_command,
    input  wire logic signed [DIR_W-1:0] move_direction,
    input  wire logic signed [ZONE_W-1:0] ball_zone
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(motion_command)
            && $stable(move_direction) && $stable(ball_zone))
        else $error("result changed while stalled");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> move_direction != 2'b10)
        else $error("invalid direction code");

    a_cmd_right: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_direction == DIR_RIGHT |->
            motion_command == CMD_STOP || motion_command == CMD_FWD_RIGHT
            || motion_command == CMD_BACK_RIGHT)
        else $error("command disagrees with right direction");

    a_cmd_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_direction == DIR_LEFT |->
            motion_command == CMD_STOP || motion_command == CMD_FWD_LEFT
            || motion_command == CMD_BACK_LEFT)
        else $error("command disagrees with left direction");

    a_cmd_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_direction == DIR_NONE |-> motion_command == CMD_STOP)
        else $error("motion without direction");

endmodule

bind ball_presence_tracker bpt_checker u_bpt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motion_command (motion_command),
    .move_direction (move_direction),
    .ball_zone      (ball_zone)
);
`default_nettype wire

[tb/tb_ball_presence_tracker.sv]
`timescale 1ns / 1ps
module tb_ball_presence_tracker;
    import bpt_pkg::*;

    localparam int HIST_DEPTH  = 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DIR_W-1:0]  dir;
        logic signed [ZONE_W-1:0] zone;
    } motion_t;

    class frame_scoreboard;
        logic [DIAM_W-1:0]        min_diam;
        logic [THR_W-1:0]         thr;
        logic [HIST_DEPTH-1:0]    history;
        logic [X_W-1:0]           held_x;
        logic signed [DIR_W-1:0]  held_dir;
        logic signed [ZONE_W-1:0] zone;
        logic [DIAM_W-1:0]        best_diam;
        logic [X_W-1:0]           best_x;
        motion_t                  motion_q[$];
        int                       errors;
        int                       items;
        int                       frames;

        function new();
            min_diam  = MIN_DIAM_RESET;
            thr       = THRESHOLD_RESET;
            history   = '0;
            held_x    = '0;
            held_dir  = DIR_NONE;
            zone      = '0;
            best_diam = '0;
            best_x    = '0;
            errors    = 0;
            items     = 0;
            frames    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_MIN_DIAM)
                min_diam = val[DIAM_W-1:0];
            else if (idx == CFG_THRESHOLD)
                thr = val[THR_W-1:0];
        endfunction

        function logic signed [ZONE_W-1:0] zone_for_x(logic [X_W-1:0] x);
            int idx;
            if (x >= IMAGE_WIDTH)
                return ZONE_W'(NUM_ZONES / 2);
            idx = x / ZONE_WIDTH;
            // no zone 0: left half maps to -4..-1, right half to 1..4
            if (idx < NUM_ZONES / 2)
                return ZONE_W'(idx - NUM_ZONES / 2);
            return ZONE_W'(idx - NUM_ZONES / 2 + 1);
        endfunction

        function int pending();
            return motion_q.size();
        endfunction

        function void note_item(logic bv, logic [DIAM_W-1:0] d, logic [X_W-1:0] x,
                                logic fl, logic obs_r, logic obs_l, logic obs_b);
            int unsigned              weight_sum;
            logic                     seen;
            logic signed [ZONE_W-1:0] new_zone;
            logic signed [DIR_W-1:0]  dir;
            motion_t                  m;
            items++;
            if (bv && d > best_diam)
            begin
                best_diam = d;
                best_x    = x;
            end
            if (!fl)
                return;
            seen    = (best_diam >= min_diam);
            history = {history[HIST_DEPTH-2:0], seen};
            weight_sum = 0;
            // newest frame weighs most
            for (int k = 0; k < HIST_DEPTH; k++)
                if (history[k])
                    weight_sum += HIST_DEPTH - k;
            if (weight_sum >= thr)
            begin
                if (seen)
                    held_x = best_x;
                new_zone = zone_for_x(held_x);
                if (new_zone == zone && (new_zone == 1 || new_zone == -1))
                    dir = DIR_NONE;
                else if (new_zone == zone && new_zone > 1)
                    dir = DIR_RIGHT;
                else if (new_zone == zone && new_zone < -1)
                    dir = DIR_LEFT;
                else if (new_zone > zone)
                    dir = DIR_RIGHT;
                else if (new_zone < zone)
                    dir = DIR_LEFT;
                else
                    dir = DIR_NONE;
                zone = new_zone;
            end
            else
            begin
                // weak evidence keeps the old direction, none at all stops
                held_x = '0;
                zone   = '0;
                dir    = (weight_sum > 0) ? held_dir : DIR_NONE;
            end
            held_dir = dir;
            if (dir == DIR_RIGHT)
                m.cmd = obs_r ? CMD_STOP : (obs_b ? CMD_FWD_RIGHT : CMD_BACK_RIGHT);
            else if (dir == DIR_LEFT)
                m.cmd = obs_l ? CMD_STOP : (obs_b ? CMD_FWD_LEFT : CMD_BACK_LEFT);
            else
                m.cmd = CMD_STOP;
            m.dir  = dir;
            m.zone = zone;
            motion_q.push_back(m);
            best_diam = '0;
            best_x    = '0;
        endfunction

        task report(string msg);
            $display("ERROR [%0t] %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [CMD_W-1:0] cmd, logic signed [DIR_W-1:0] dir,
                          logic signed [ZONE_W-1:0] z);
            motion_t m;
            if (motion_q.size() == 0)
            begin
                report($sformatf("unexpected result cmd=%0d dir=%0d zone=%0d", cmd, dir, z));
                return;
            end
            m = motion_q.pop_front();
            frames++;
            if (cmd !== m.cmd)
                report($sformatf("frame %0d motion_command %0d, want %0d", frames, cmd, m.cmd));
            if (dir !== m.dir)
                report($sformatf("frame %0d move_direction %0d, want %0d", frames, dir, m.dir));
            if (z !== m.zone)
                report($sformatf("frame %0d ball_zone %0d, want %0d", frames, z, m.zone));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           ball_valid;
    logic [DIAM_W-1:0]              ball_diameter;
    logic [X_W-1:0]                 ball_x;
    logic                           frame_last;
    logic                           obstacle_right;
    logic                           obstacle_left;
    logic                           obstacle_back;
    logic                           out_valid;
    logic                           out_ready;
    logic [CMD_W-1:0]               motion_command;
    logic signed [DIR_W-1:0]        move_direction;
    logic signed [ZONE_W-1:0]       ball_zone;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;

    frame_scoreboard sb;
    bit              no_gaps;
    int              quiet_cycles;
    int              settings_used;

    ball_presence_tracker #(.HISTORY_DEPTH(HIST_DEPTH)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ball_valid     (ball_valid),
        .ball_diameter  (ball_diameter),
        .ball_x         (ball_x),
        .frame_last     (frame_last),
        .obstacle_right (obstacle_right),
        .obstacle_left  (obstacle_left),
        .obstacle_back  (obstacle_back),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .motion_command (motion_command),
        .move_direction (move_direction),
        .ball_zone      (ball_zone),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= no_gaps || ($urandom_range(99) >= 7);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(motion_command, move_direction, ball_zone);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic bv, input logic [DIAM_W-1:0] d,
                             input logic [X_W-1:0] x, input logic fl,
                             input logic obs_r, input logic obs_l, input logic obs_b);
        while (!no_gaps && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        ball_valid     <= bv;
        ball_diameter  <= d;
        ball_x         <= x;
        frame_last     <= fl;
        obstacle_right <= obs_r;
        obstacle_left  <= obs_l;
        obstacle_back  <= obs_b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(bv, d, x, fl, obs_r, obs_l, obs_b);
    endtask

    task automatic apply_settings(input logic [DIAM_W-1:0] min_d, input logic [THR_W-1:0] t);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MIN_DIAM;
        cfg_data  <= CFG_DATA_W'(min_d);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(CFG_MIN_DIAM, CFG_DATA_W'(min_d));
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(t);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(CFG_THRESHOLD, CFG_DATA_W'(t));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // only called at a frame boundary; the extra cycles cover the back-end latency
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // runs of frames sharing a presence rate, with a ball x that drifts across zones
    task automatic run_frames(input int n_items);
        int sent;
        int present_pct;
        int run_len;
        int n_in_frame;
        int x_track;
        int d;
        int x;
        bit want_seen;
        bit bv;
        sent    = 0;
        x_track = $urandom_range(0, IMAGE_WIDTH);
        // empty frame and zero-diameter ball under the new setting
        send_item(1'b0, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_item(1'b1, '0, X_W'($urandom_range(0, 1023)), 1'b1, 1'b1, 1'b1, 1'b1);
        while (sent < n_items)
        begin
            case ($urandom_range(2))
                0: present_pct = 95;
                1: present_pct = 60;
                default: present_pct = 5;
            endcase
            run_len = $urandom_range(2, 14);
            for (int f = 0; f < run_len; f++)
            begin
                n_in_frame = ($urandom_range(99) < 40) ? 1 : $urandom_range(2, 4);
                want_seen  = ($urandom_range(99) < present_pct);
                for (int i = 0; i < n_in_frame; i++)
                begin
                    bv = ($urandom_range(99) < 85);
                    if ($urandom_range(99) < 10)
                        d = $urandom_range(0, 255);
                    else if (want_seen)
                        d = $urandom_range(sb.min_diam, 255);
                    else if (sb.min_diam > 0)
                        d = $urandom_range(0, sb.min_diam - 1);
                    else
                        d = 0;
                    x_track = x_track + $urandom_range(0, 80) - 40;
                    if (x_track < 0)
                        x_track = 0;
                    if (x_track > IMAGE_WIDTH + 20)
                        x_track = IMAGE_WIDTH + 20;
                    x = ($urandom_range(99) < 5) ? $urandom_range(0, 1023) : x_track;
                    send_item(bv, DIAM_W'(d), X_W'(x), i == n_in_frame - 1,
                              $urandom_range(99) < 30, $urandom_range(99) < 30,
                              $urandom_range(99) < 50);
                    sent++;
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        ball_valid     = 1'b0;
        ball_diameter  = '0;
        ball_x         = '0;
        frame_last     = 1'b0;
        obstacle_right = 1'b0;
        obstacle_left  = 1'b0;
        obstacle_back  = 1'b0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_MIN_DIAM;
        cfg_data       = '0;
        no_gaps        = 1'b0;
        quiet_cycles   = 0;
        settings_used  = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at reset settings
        send_item(1'b0, 8'd0,   10'd0,    1'b1, 1'b0, 1'b0, 1'b0);  // empty frame
        send_item(1'b1, 8'd0,   10'd100,  1'b1, 1'b0, 1'b0, 1'b0);  // zero diameter
        send_item(1'b0, 8'd255, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1);  // no ball flag
        send_item(1'b1, 8'd10,  10'd20,   1'b0, 1'b1, 1'b1, 1'b1);  // tie, first kept
        send_item(1'b1, 8'd10,  10'd300,  1'b1, 1'b0, 1'b0, 1'b0);  // weak evidence
        send_item(1'b1, 8'd255, 10'd0,    1'b1, 1'b0, 1'b0, 1'b0);  // now tracked
        send_item(1'b1, 8'd4,   10'd39,   1'b1, 1'b0, 1'b0, 1'b1);
        send_item(1'b1, 8'd5,   10'd40,   1'b1, 1'b1, 1'b0, 1'b0);
        send_item(1'b1, 8'd3,   10'd500,  1'b0, 1'b0, 1'b0, 1'b0);  // below minimum
        send_item(1'b1, 8'd6,   10'd159,  1'b1, 1'b0, 1'b0, 1'b1);
        send_item(1'b1, 8'd200, 10'd160,  1'b1, 1'b0, 1'b0, 1'b1);
        send_item(1'b1, 8'd200, 10'd199,  1'b1, 1'b0, 1'b0, 1'b0);
        send_item(1'b1, 8'd128, 10'd319,  1'b1, 1'b0, 1'b0, 1'b0);
        send_item(1'b1, 8'd128, 10'd320,  1'b1, 1'b0, 1'b0, 1'b1);
        send_item(1'b1, 8'd127, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0);
        send_item(1'b1, 8'd255, 10'd120,  1'b1, 1'b0, 1'b1, 1'b0);
        send_item(1'b1, 8'd255, 10'd80,   1'b1, 1'b0, 1'b0, 1'b0);
        // tracked but unseen, then history decays through weak to none
        for (int i = 0; i < 8; i++)
            send_item(1'b0, 8'd0, 10'd0, 1'b1, i[0], i[1], i[2]);
        wait_idle();

        run_frames(320);
        apply_settings(8'd0, 6'd0);
        run_frames(320);
        apply_settings(8'd255, 6'd63);
        run_frames(300);
        apply_settings(8'd1, 6'd36);
        run_frames(320);
        apply_settings(DIAM_W'($urandom_range(0, 40)), THR_W'($urandom_range(0, 63)));
        run_frames(320);
        apply_settings(MIN_DIAM_RESET, THRESHOLD_RESET);
        no_gaps = 1'b1;
        run_frames(320);
        no_gaps = 1'b0;

        $display("Run covered %0d input items and %0d checked motion commands", sb.items,
                 sb.frames);
        $display("across %0d register settings, %0d mismatches", settings_used, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/bpt_pkg.sv
hdl/bpt_front.sv
hdl/bpt_queue.sv
hdl/bpt_back.sv
hdl/ball_presence_tracker.sv
hdl/bpt_checker.sv
tb/tb_ball_presence_tracker.sv
